### src/swma_pkg.sv
// ----------------------------------------------------------------------------
// swma_pkg
// shared types and constants of the sliding window moving average
// ----------------------------------------------------------------------------
package swma_pkg;

    // fixed widths of the result fields and the window size register
    localparam int AVG_BITS = 26;
    localparam int CNT_BITS = 11;
    localparam int CFG_BITS = 11;

    // saturation limits of the average
    localparam logic signed [AVG_BITS-1:0] AVG_MAX = {1'b0, {(AVG_BITS-1){1'b1}}};
    localparam logic signed [AVG_BITS-1:0] AVG_MIN = {1'b1, {(AVG_BITS-1){1'b0}}};

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch sample, start ring read
        logic update;   // running sum, count, ring write
        logic setup;    // load divider operands
        logic step;     // one quotient bit
        logic emit;     // load the output register
    } cmd_t;

endpackage

### src/swma_sample_if.sv
// ----------------------------------------------------------------------------
// swma_sample_if
// valid/ready channel carrying one input sample
// ----------------------------------------------------------------------------
interface swma_sample_if #(
    parameter int SAMPLE_BITS = 18
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### src/swma_result_if.sv
// ----------------------------------------------------------------------------
// swma_result_if
// valid/ready channel carrying one average and its sample count
// ----------------------------------------------------------------------------
interface swma_result_if;
    import swma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [AVG_BITS-1:0] average;
    logic [CNT_BITS-1:0]        held_count;

    modport source (output valid, output average, output held_count, input ready);
    modport sink   (input valid, input average, input held_count, output ready);
endinterface

### src/swma_ram.sv
// ----------------------------------------------------------------------------
// swma_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module swma_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

### src/swma_ctrl.sv
// ----------------------------------------------------------------------------
// swma_ctrl
// controller: sequences accept, sum update, serial divide and output load
// ----------------------------------------------------------------------------
module swma_ctrl #(
    parameter int DIV_STEPS = 37
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output swma_pkg::cmd_t cmd
);
    import swma_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_SETUP  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // an accepted request goes straight to the sum update
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.update)
        else $error("sum update did not follow accept");

    // divider count stays within the quotient width
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) |-> (cnt_reg <= CW'(DIV_STEPS - 1)))
        else $error("divider count out of range");

    // setup, then one divide cycle per quotient bit, then finish
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.setup |-> ##(DIV_STEPS + 1) (state_reg == S_FINISH))
        else $error("divide phase length wrong");
endmodule

### src/swma_datapath.sv
// ----------------------------------------------------------------------------
// swma_datapath
// datapath: window register, running sum, fill count, bit serial divider
// ----------------------------------------------------------------------------
module swma_datapath #(
    parameter int MAX_WINDOW    = 1024,
    parameter int SAMPLE_BITS   = 18,
    parameter int FRACTION_BITS = 8,
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int CW = $clog2(MAX_WINDOW + 1),
    localparam int SW = SAMPLE_BITS + CW,
    localparam int NW = SW + FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swma_pkg::cmd_t                      cmd,
    input  logic                                cfg_we,
    input  logic [swma_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic [AW-1:0]                       ram_raddr,
    input  logic [SAMPLE_BITS-1:0]              ram_rdata,
    output logic                                ram_we,
    output logic [AW-1:0]                       ram_waddr,
    output logic [SAMPLE_BITS-1:0]              ram_wdata,
    output logic signed [swma_pkg::AVG_BITS-1:0] average,
    output logic [swma_pkg::CNT_BITS-1:0]       held_count
);
    import swma_pkg::*;

    localparam logic [63:0] POS_LIM = 64'((64'd1 << (AVG_BITS - 1)) - 64'd1);
    localparam logic [63:0] NEG_LIM = 64'd1 << (AVG_BITS - 1);

    logic [CFG_BITS-1:0]         window_reg, window_next;
    logic [AW-1:0]               slot_reg, slot_next;
    logic [CW-1:0]               fill_reg, fill_next;
    logic signed [SW-1:0]        sum_reg, sum_next;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [NW-1:0]               num_reg;
    logic [CW-1:0]               rem_reg;
    logic                        neg_reg;
    logic signed [AVG_BITS-1:0]  avg_reg, avg_next;
    logic [CNT_BITS-1:0]         held_reg;

    logic [31:0]                 ws32, win32;
    logic [CW-1:0]               win_eff;
    logic                        full;
    logic signed [SW-1:0]        oldest;
    logic [SW-1:0]               mag;
    logic [CW:0]                 rem_shift, div_ext;
    logic                        q_bit;
    logic [CW-1:0]               rem_next;
    logic [63:0]                 q64;

    // effective window, clamped to 1..MAX_WINDOW
    always_comb
    begin
        ws32 = 32'(window_reg);
        if (ws32 == 32'd0)
        begin
            win32 = 32'd1;
        end
        else if (ws32 > 32'(MAX_WINDOW))
        begin
            win32 = 32'(MAX_WINDOW);
        end
        else
        begin
            win32 = ws32;
        end
        win_eff = CW'(win32);
    end

    // ring access: read at accept, write back the new sample at update
    assign ram_raddr = slot_reg;
    assign ram_we    = cmd.update;
    assign ram_waddr = slot_reg;
    assign ram_wdata = sample_reg;

    // running sum and pointers
    always_comb
    begin
        full        = (fill_reg >= win_eff);
        oldest      = full ? SW'($signed(ram_rdata)) : '0;
        window_next = window_reg;
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        if (cfg_we)
        begin
            window_next = cfg_wdata;
            slot_next   = '0;
            fill_next   = '0;
            sum_next    = '0;
        end
        else if (cmd.update)
        begin
            sum_next = sum_reg + SW'(sample_reg) - oldest;
            if (!full)
            begin
                fill_next = fill_reg + 1'b1;
            end
            if ((32'(slot_reg) + 32'd1) >= 32'(win_eff))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= CFG_BITS'(1);
            slot_reg   <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            window_reg <= window_next;
            slot_reg   <= slot_next;
            fill_reg   <= fill_next;
            sum_reg    <= sum_next;
        end
    end

    // restoring divide step, quotient shifts into the numerator register
    assign mag       = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign rem_shift = {rem_reg, num_reg[NW-1]};
    assign div_ext   = {1'b0, fill_reg};
    assign q_bit     = (rem_shift >= div_ext);
    assign rem_next  = q_bit ? CW'(rem_shift - div_ext) : rem_shift[CW-1:0];

    // sign and saturation of the quotient
    always_comb
    begin
        q64 = 64'(num_reg);
        if (neg_reg)
        begin
            avg_next = (q64 > NEG_LIM) ? AVG_MIN : -AVG_BITS'(q64);
        end
        else
        begin
            avg_next = (q64 > POS_LIM) ? AVG_MAX : AVG_BITS'(q64);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        if (cmd.setup)
        begin
            neg_reg <= sum_reg[SW-1];
            num_reg <= NW'(mag) << FRACTION_BITS;
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            num_reg <= {num_reg[NW-2:0], q_bit};
            rem_reg <= rem_next;
        end
        if (cmd.emit)
        begin
            avg_reg  <= avg_next;
            held_reg <= CNT_BITS'(fill_reg);
        end
    end

    assign average    = avg_reg;
    assign held_count = held_reg;

    // the fill count never passes the window
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("fill count beyond window");

    // the divisor is never zero while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.setup || cmd.step) |-> (fill_reg != '0))
        else $error("divide by zero count");

    // the write slot stays inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < 32'(win_eff))
        else $error("write slot outside window");
endmodule

### src/sliding_window_moving_average.sv
// ----------------------------------------------------------------------------
// sliding_window_moving_average
// mean of the last window_size samples, signed fixed point, truncated to zero
// sequence: accept, sum update, divider setup, then the bit serial divider at one
//   quotient bit per cycle, then output load into the result register
// requests: a new request is accepted only after the previous result is loaded;
//   the output register lets the next request enter while a result waits
// reset: window size 1, count, slot and sum cleared; ring contents undefined
// ----------------------------------------------------------------------------
module sliding_window_moving_average #(
    parameter int MAX_WINDOW    = 1024,
    parameter int SAMPLE_BITS   = 18,
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    swma_sample_if.sink                   samples,
    swma_result_if.source                 results,
    input  logic                          cfg_we,
    input  logic [swma_pkg::CFG_BITS-1:0] cfg_wdata
);
    import swma_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int NW = SAMPLE_BITS + CW + FRACTION_BITS;

    cmd_t                   cmd;
    logic [AW-1:0]          ram_raddr;
    logic [AW-1:0]          ram_waddr;
    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // sequencer
    swma_ctrl #(
        .DIV_STEPS (NW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    // sum, pointers and divider
    swma_datapath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .sample     (samples.sample),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .average    (results.average),
        .held_count (results.held_count)
    );

    // sample ring
    swma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule
